// ----- design/fit_policy_block_allocator_defines.svh -----
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define FPBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define FPBA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FPBA_ASSERT(lbl, prop, msg)
`define FPBA_NEVER(lbl, cond, msg)
`endif
`endif

// ----- design/fpba_pkg.sv -----
// Types, codes and constants of the fit-policy block allocator.
package fpba_pkg;
  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned HeaderBytesDef = 16;
  localparam int unsigned AddrW  = 20;
  localparam int unsigned SizeW  = 21;
  localparam int unsigned OwnerW = 16;
  localparam int unsigned NeedW  = 22;
  localparam int unsigned EndW   = 23;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [SizeW-1:0] PoolLimit = SizeW'(1048576);

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_SPARE = 2'd3
  } fit_e;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FAILED    = 2'd1,
    ST_RELEASED  = 2'd2,
    ST_MISSING   = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FIT  = 1'b0,
    REG_POOL = 1'b1
  } reg_e;

  typedef struct packed {
    logic [AddrW-1:0]  start;
    logic [SizeW-1:0]  bytes;
    logic [OwnerW-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic              release_op;
    logic [NeedW-1:0]  need;
    logic [SizeW-1:0]  pool;
    logic [OwnerW-1:0] key;
    logic              ins;
    logic              rem;
  } cell_ctl_t;

  // True when the later candidate b beats the earlier candidate a.
  function automatic logic pick_later(fit_e mode, logic a_found, logic [SizeW-1:0] a_gap,
                                      logic b_found, logic [SizeW-1:0] b_gap);
    logic win;
    win = 1'b0;
    if (b_found) begin
      if (!a_found) begin
        win = 1'b1;
      end else if (mode == FIT_BEST) begin
        win = b_gap < a_gap;
      end else if (mode == FIT_WORST) begin
        win = b_gap > a_gap;
      end
    end
    return win;
  endfunction
endpackage

// ----- design/fpba_if.sv -----
// Valid/ready channel interfaces for allocator requests and responses.
interface fpba_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [fpba_pkg::SizeW-1:0]   request_bytes;
  logic [fpba_pkg::OwnerW-1:0]  owner_id;
  modport source (output valid, action, request_bytes, owner_id, input ready);
  modport sink   (input valid, action, request_bytes, owner_id, output ready);
endinterface

interface fpba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [fpba_pkg::AddrW-1:0]  block_address;
  modport source (output valid, status, block_address, input ready);
  modport sink   (input valid, status, block_address, output ready);
endinterface

// ----- design/fpba_cell.sv -----
// One table slot: holds an entry, scores the gap before it, shifts with its neighbors.
module fpba_cell #(
  parameter int unsigned Index       = 0,
  parameter int unsigned IdxW        = 6,
  parameter int unsigned HeaderBytes = fpba_pkg::HeaderBytesDef
) (
  input  logic                        clk_i,
  input  fpba_pkg::entry_t            left_i,
  input  fpba_pkg::entry_t            right_i,
  input  fpba_pkg::entry_t            new_i,
  output fpba_pkg::entry_t            ent_o,
  input  logic                        valid_i,
  input  logic                        boundary_i,
  input  logic [fpba_pkg::EndW-1:0]   prev_end_i,
  output logic [fpba_pkg::EndW-1:0]   end_o,
  input  fpba_pkg::cell_ctl_t         ctl_i,
  input  logic [IdxW-1:0]             pos_i,
  output logic                        found_o,
  output logic [fpba_pkg::SizeW-1:0]  gap_o,
  output logic [fpba_pkg::AddrW-1:0]  addr_o
);
  import fpba_pkg::*;

  entry_t          ent_q, ent_d;
  logic [EndW-1:0] lim, gapw;
  logic            start_ok, lim_ge, fits;
  logic [IdxW-1:0] me;

  assign me    = IdxW'(Index);
  assign ent_o = ent_q;
  assign end_o = EndW'(ent_q.start) + EndW'(HeaderBytes) + EndW'(ent_q.bytes);

  always_comb begin
    ent_d = ent_q;
    if (ctl_i.ins) begin
      if (me == pos_i) begin
        ent_d = new_i;
      end else if (me > pos_i) begin
        ent_d = left_i;
      end
    end else if (ctl_i.rem && me >= pos_i) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  // Gap runs from the previous block's end to this block's start, or to the pool end.
  assign lim      = valid_i ? EndW'(ent_q.start) : EndW'(ctl_i.pool);
  assign start_ok = prev_end_i < EndW'(PoolLimit);
  assign lim_ge   = lim >= prev_end_i;
  assign gapw     = lim - prev_end_i;
  assign fits     = gapw >= EndW'(ctl_i.need);

  always_comb begin
    if (ctl_i.release_op) begin
      found_o = valid_i && (ent_q.owner == ctl_i.key);
      gap_o   = '0;
      addr_o  = ent_q.start;
    end else begin
      found_o = (valid_i || boundary_i) && start_ok && lim_ge && fits;
      gap_o   = gapw[SizeW-1:0];
      addr_o  = prev_end_i[AddrW-1:0];
    end
  end
endmodule

// ----- design/fpba_select.sv -----
// Registered selection tree that picks the winning slot by fit policy.
module fpba_select #(
  parameter int unsigned NumCells = fpba_pkg::MaxBlocksDef,
  parameter int unsigned Levels   = $clog2(NumCells)
) (
  input  logic                        clk_i,
  input  fpba_pkg::fit_e              mode_i,
  input  logic [NumCells-1:0]         found_i,
  input  logic [fpba_pkg::SizeW-1:0]  gap_i  [NumCells],
  input  logic [fpba_pkg::AddrW-1:0]  addr_i [NumCells],
  output logic                        found_o,
  output logic [fpba_pkg::AddrW-1:0]  addr_o,
  output logic [Levels-1:0]           idx_o
);
  import fpba_pkg::*;

  localparam int unsigned Leaves = 1 << Levels;
  localparam int unsigned Nodes  = 2 * Leaves - 1;

  logic              fnd_q [Nodes];
  logic [SizeW-1:0]  gap_q [Nodes];
  logic [AddrW-1:0]  adr_q [Nodes];
  logic [Levels-1:0] idx_q [Nodes];

  for (genvar i = 0; i < Leaves; i++) begin : g_leaf
    if (i < NumCells) begin : g_real
      always_ff @(posedge clk_i) begin
        fnd_q[Leaves-1+i] <= found_i[i];
        gap_q[Leaves-1+i] <= gap_i[i];
        adr_q[Leaves-1+i] <= addr_i[i];
        idx_q[Leaves-1+i] <= Levels'(i);
      end
    end else begin : g_pad
      always_ff @(posedge clk_i) begin
        fnd_q[Leaves-1+i] <= 1'b0;
        gap_q[Leaves-1+i] <= '0;
        adr_q[Leaves-1+i] <= '0;
        idx_q[Leaves-1+i] <= Levels'(i);
      end
    end
  end

  for (genvar k = 0; k < Leaves - 1; k++) begin : g_node
    logic take_b;
    assign take_b = pick_later(mode_i, fnd_q[2*k+1], gap_q[2*k+1],
                               fnd_q[2*k+2], gap_q[2*k+2]);
    always_ff @(posedge clk_i) begin
      fnd_q[k] <= take_b ? fnd_q[2*k+2] : fnd_q[2*k+1];
      gap_q[k] <= take_b ? gap_q[2*k+2] : gap_q[2*k+1];
      adr_q[k] <= take_b ? adr_q[2*k+2] : adr_q[2*k+1];
      idx_q[k] <= take_b ? idx_q[2*k+2] : idx_q[2*k+1];
    end
  end

  assign found_o = fnd_q[0];
  assign addr_o  = adr_q[0];
  assign idx_o   = idx_q[0];
endmodule

// ----- design/fit_policy_block_allocator.sv -----
// Top level of the fit-policy block allocator.
// The block table lives in a row of MaxBlocks cells kept in address order; each
// cell scores the gap in front of it, a registered selection tree of
// log2(MaxBlocks) levels picks the winner (lowest index on ties), and the row
// then shifts one place left or right to insert or remove. After acceptance the
// cell scores are registered at the tree leaves, pass through the registered
// tree levels, and the row shifts in the apply state to give the response. The
// next request is taken only once the block is back in idle, so one word is in
// flight at a time. The response sits in an output register, so the next
// request is taken while a response still waits; a second result stalls the
// apply cycle until the first is claimed. An allocate into a full table fails
// even if an inner gap fits.
// Configuration writes apply immediately and are expected only while the block
// is idle.
`include "fit_policy_block_allocator_defines.svh"
module fit_policy_block_allocator #(
  parameter int unsigned MaxBlocks   = fpba_pkg::MaxBlocksDef,
  parameter int unsigned HeaderBytes = fpba_pkg::HeaderBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [fpba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fpba_pkg::SizeW-1:0]    cfg_data_i,
  fpba_req_if.sink                      req,
  fpba_rsp_if.source                    rsp
);
  import fpba_pkg::*;

  localparam int unsigned Levels = $clog2(MaxBlocks);
  localparam int unsigned CntW   = $clog2(MaxBlocks + 1);
  localparam int unsigned RunW   = $clog2(Levels + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [RunW-1:0]   run_q;
  logic [CntW-1:0]   count_q;
  logic [1:0]        fit_q;
  logic [SizeW-1:0]  pool_q;
  logic              act_q;
  logic [SizeW-1:0]  req_bytes_q;
  logic [OwnerW-1:0] owner_q;
  logic              out_valid_q;
  logic [1:0]        out_status_q;
  logic [AddrW-1:0]  out_addr_q;

  logic              apply_go;
  cell_ctl_t         ctl;
  entry_t            new_ent;
  entry_t            ent   [MaxBlocks];
  logic [EndW-1:0]   ends  [MaxBlocks];
  logic [MaxBlocks-1:0] found;
  logic [SizeW-1:0]  gaps  [MaxBlocks];
  logic [AddrW-1:0]  addrs [MaxBlocks];
  fit_e              mode;
  logic              win_found;
  logic              win_ok;
  logic [AddrW-1:0]  win_addr;
  logic [Levels-1:0] win_idx;

  // Configuration registers; an oversized pool clamps to the address space.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_q  <= FIT_FIRST;
      pool_q <= PoolLimit;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIT:  fit_q  <= cfg_data_i[1:0];
        REG_POOL: pool_q <= (cfg_data_i > PoolLimit) ? PoolLimit : cfg_data_i;
        default:  ;
      endcase
    end
  end

  assign req.ready = (state_q == S_IDLE);

  // Hold the accepted word for the whole evaluation.
  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      act_q       <= req.action;
      req_bytes_q <= req.request_bytes;
      owner_q     <= req.owner_id;
    end
  end

  // Wait in apply while the previous response is still unclaimed.
  assign apply_go = (state_q == S_APPLY) && (!out_valid_q || rsp.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (req.valid) state_d = S_RUN;
      S_RUN:   if (run_q == RunW'(Levels)) state_d = S_APPLY;
      S_APPLY: if (apply_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      run_q   <= '0;
    end else begin
      state_q <= state_d;
      run_q   <= (state_q == S_RUN) ? run_q + RunW'(1) : '0;
    end
  end

  // Drop an allocate into a full table even when an inner gap would fit.
  assign win_ok = win_found && !((act_q == ACT_ALLOC) && (count_q == CntW'(MaxBlocks)));

  assign ctl.release_op = (act_q == ACT_FREE);
  assign ctl.need       = NeedW'(req_bytes_q) + NeedW'(HeaderBytes);
  assign ctl.pool       = pool_q;
  assign ctl.key        = owner_q;
  assign ctl.ins        = apply_go && (act_q == ACT_ALLOC) && win_ok;
  assign ctl.rem        = apply_go && (act_q == ACT_FREE) && win_ok;

  assign new_ent.start = win_addr;
  assign new_ent.bytes = req_bytes_q;
  assign new_ent.owner = owner_q;

  // Release always takes the lowest matching slot; unused code 3 acts as first fit.
  always_comb begin
    if (act_q == ACT_FREE) begin
      mode = FIT_FIRST;
    end else begin
      case (fit_q)
        FIT_BEST:  mode = FIT_BEST;
        FIT_WORST: mode = FIT_WORST;
        default:   mode = FIT_FIRST;
      endcase
    end
  end

  for (genvar i = 0; i < MaxBlocks; i++) begin : g_cell
    logic [EndW-1:0] prev_end;
    entry_t          left, right;
    assign prev_end = (i == 0) ? '0 : ends[(i == 0) ? 0 : i-1];
    assign left     = (i == 0) ? new_ent : ent[(i == 0) ? 0 : i-1];
    assign right    = (i == MaxBlocks-1) ? ent[i] : ent[(i == MaxBlocks-1) ? i : i+1];

    fpba_cell #(
      .Index       (i),
      .IdxW        (Levels),
      .HeaderBytes (HeaderBytes)
    ) u_cell (
      .clk_i      (clk_i),
      .left_i     (left),
      .right_i    (right),
      .new_i      (new_ent),
      .ent_o      (ent[i]),
      .valid_i    (CntW'(i) < count_q),
      .boundary_i (CntW'(i) == count_q),
      .prev_end_i (prev_end),
      .end_o      (ends[i]),
      .ctl_i      (ctl),
      .pos_i      (win_idx),
      .found_o    (found[i]),
      .gap_o      (gaps[i]),
      .addr_o     (addrs[i])
    );
  end

  fpba_select #(
    .NumCells (MaxBlocks),
    .Levels   (Levels)
  ) u_select (
    .clk_i   (clk_i),
    .mode_i  (mode),
    .found_i (found),
    .gap_i   (gaps),
    .addr_i  (addrs),
    .found_o (win_found),
    .addr_o  (win_addr),
    .idx_o   (win_idx)
  );

  // Advance the entry count with the shift of the row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl.ins) begin
      count_q <= count_q + CntW'(1);
    end else if (ctl.rem) begin
      count_q <= count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (apply_go) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      out_addr_q <= win_ok ? win_addr : '0;
      if (act_q == ACT_FREE) begin
        out_status_q <= win_ok ? ST_RELEASED : ST_MISSING;
      end else begin
        out_status_q <= win_ok ? ST_ALLOCATED : ST_FAILED;
      end
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.block_address = out_addr_q;

  `FPBA_NEVER(a_count_bound, count_q > CntW'(MaxBlocks), "entry count above table depth")
  `FPBA_ASSERT(a_ins_grows, ctl.ins |=> count_q == $past(count_q) + CntW'(1), "insert lost")
  `FPBA_ASSERT(a_fail_zero, rsp.valid && (rsp.status == ST_FAILED || rsp.status == ST_MISSING) |-> rsp.block_address == '0, "failure with address")
  `FPBA_ASSERT(a_accept_run, req.valid && req.ready |=> state_q == S_RUN, "accept did not start")
endmodule
